// ----- src/fte_pkg.sv -----
package fte_pkg;

    localparam int SAMPLE_BITS   = 10;
    localparam int TIME_BITS     = 24;
    localparam int LEN_BITS      = 16;
    localparam int RATIO_BITS    = 17;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 24;
    localparam int Q_DEPTH       = 2;
    localparam int Q_PTR_BITS    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_BITS    = $clog2(Q_DEPTH + 1);

    localparam logic [TIME_BITS-1:0]   J_START_RST = TIME_BITS'(2000);
    localparam logic [TIME_BITS-1:0]   I_START_RST = TIME_BITS'(30000);
    localparam logic [LEN_BITS-1:0]    WIN_LEN_RST = LEN_BITS'(1000);
    localparam logic [SAMPLE_BITS-1:0] SAT_RST     = SAMPLE_BITS'(1023);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_J_START   = 2'd0,
        CFG_I_START   = 2'd1,
        CFG_WIN_LEN   = 2'd2,
        CFG_SAT_LEVEL = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample;
        logic [TIME_BITS-1:0]   time_us;
        logic                   last_sample;
    } fte_in_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] fo_level;
        logic [SAMPLE_BITS-1:0] fj_level;
        logic [TIME_BITS-1:0]   fj_time_us;
        logic [SAMPLE_BITS-1:0] fi_level;
        logic [TIME_BITS-1:0]   fi_time_us;
        logic [SAMPLE_BITS-1:0] fm_level;
        logic [TIME_BITS-1:0]   fm_time_us;
        logic [SAMPLE_BITS-1:0] fv_level;
        logic [RATIO_BITS-1:0]  yield_ratio;
        logic                   fj_found;
        logic                   fi_found;
        logic                   saturated;
    } fte_out_t;

    typedef struct packed {
        logic [TIME_BITS-1:0]   j_start;
        logic [TIME_BITS-1:0]   i_start;
        logic [LEN_BITS-1:0]    win_len;
        logic [SAMPLE_BITS-1:0] sat_level;
    } fte_cfg_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] fo_level;
        logic [SAMPLE_BITS-1:0] fj_level;
        logic [TIME_BITS-1:0]   fj_time_us;
        logic [SAMPLE_BITS-1:0] fi_level;
        logic [TIME_BITS-1:0]   fi_time_us;
        logic [SAMPLE_BITS-1:0] fm_level;
        logic [TIME_BITS-1:0]   fm_time_us;
        logic                   fj_found;
        logic                   fi_found;
        logic                   saturated;
    } fte_rec_t;

    typedef struct packed {
        logic     valid;
        fte_rec_t rec;
    } fte_push_t;

endpackage

// ----- src/fte_front.sv -----
module fte_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  fte_pkg::fte_cfg_t cfg,
    input  logic             s_valid,
    output logic             s_ready,
    input  fte_pkg::fte_in_t s_data,
    input  logic             q_full,
    output fte_pkg::fte_push_t push
);
    import fte_pkg::*;

    logic                   run_start_reg, run_start_next;
    logic [SAMPLE_BITS-1:0] first_reg, first_next;
    logic [SAMPLE_BITS-1:0] peak_reg, peak_next;
    logic [TIME_BITS-1:0]   peak_time_reg, peak_time_next;
    logic [SAMPLE_BITS-1:0] j_level_reg, j_level_next;
    logic [TIME_BITS-1:0]   j_time_reg, j_time_next;
    logic                   j_seen_reg, j_seen_next;
    logic [SAMPLE_BITS-1:0] i_level_reg, i_level_next;
    logic [TIME_BITS-1:0]   i_time_reg, i_time_next;
    logic                   i_seen_reg, i_seen_next;

    logic                   accept;
    logic                   j_hit;
    logic                   i_hit;
    logic [SAMPLE_BITS-1:0] upd_first;
    logic [SAMPLE_BITS-1:0] upd_peak;
    logic [TIME_BITS-1:0]   upd_peak_time;
    logic [SAMPLE_BITS-1:0] upd_j_level;
    logic [TIME_BITS-1:0]   upd_j_time;
    logic [SAMPLE_BITS-1:0] upd_i_level;
    logic [TIME_BITS-1:0]   upd_i_time;

    function automatic logic in_win(input logic [TIME_BITS-1:0] t,
                                    input logic [TIME_BITS-1:0] start,
                                    input logic [LEN_BITS-1:0]  len);
        logic [TIME_BITS:0] win_end;
        win_end = {1'b0, start} + {{(TIME_BITS+1-LEN_BITS){1'b0}}, len};
        return (t >= start) && ({1'b0, t} < win_end);
    endfunction

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    assign j_hit = !j_seen_reg && in_win(s_data.time_us, cfg.j_start, cfg.win_len);
    assign i_hit = !i_seen_reg && in_win(s_data.time_us, cfg.i_start, cfg.win_len);

    always_comb begin
        upd_first     = first_reg;
        upd_peak      = peak_reg;
        upd_peak_time = peak_time_reg;
        if (run_start_reg) begin
            upd_first     = s_data.sample;
            upd_peak      = s_data.sample;
            upd_peak_time = s_data.time_us;
        end else if (s_data.sample > peak_reg) begin
            upd_peak      = s_data.sample;
            upd_peak_time = s_data.time_us;
        end
        upd_j_level = j_hit ? s_data.sample  : j_level_reg;
        upd_j_time  = j_hit ? s_data.time_us : j_time_reg;
        upd_i_level = i_hit ? s_data.sample  : i_level_reg;
        upd_i_time  = i_hit ? s_data.time_us : i_time_reg;
    end

    always_comb begin
        push.valid           = accept && s_data.last_sample;
        push.rec.fo_level    = upd_first;
        push.rec.fj_level    = upd_j_level;
        push.rec.fj_time_us  = upd_j_time;
        push.rec.fi_level    = upd_i_level;
        push.rec.fi_time_us  = upd_i_time;
        push.rec.fm_level    = upd_peak;
        push.rec.fm_time_us  = upd_peak_time;
        push.rec.fj_found    = j_seen_reg || j_hit;
        push.rec.fi_found    = i_seen_reg || i_hit;
        push.rec.saturated   = (upd_peak == cfg.sat_level);
    end

    always_comb begin
        run_start_next = run_start_reg;
        first_next     = first_reg;
        peak_next      = peak_reg;
        peak_time_next = peak_time_reg;
        j_level_next   = j_level_reg;
        j_time_next    = j_time_reg;
        j_seen_next    = j_seen_reg;
        i_level_next   = i_level_reg;
        i_time_next    = i_time_reg;
        i_seen_next    = i_seen_reg;
        if (accept) begin
            if (s_data.last_sample) begin
                run_start_next = 1'b1;
                first_next     = '0;
                peak_next      = '0;
                peak_time_next = '0;
                j_level_next   = '0;
                j_time_next    = '0;
                j_seen_next    = 1'b0;
                i_level_next   = '0;
                i_time_next    = '0;
                i_seen_next    = 1'b0;
            end else begin
                run_start_next = 1'b0;
                first_next     = upd_first;
                peak_next      = upd_peak;
                peak_time_next = upd_peak_time;
                j_level_next   = upd_j_level;
                j_time_next    = upd_j_time;
                j_seen_next    = j_seen_reg || j_hit;
                i_level_next   = upd_i_level;
                i_time_next    = upd_i_time;
                i_seen_next    = i_seen_reg || i_hit;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_start_reg <= 1'b1;
            first_reg     <= '0;
            peak_reg      <= '0;
            peak_time_reg <= '0;
            j_level_reg   <= '0;
            j_time_reg    <= '0;
            j_seen_reg    <= 1'b0;
            i_level_reg   <= '0;
            i_time_reg    <= '0;
            i_seen_reg    <= 1'b0;
        end else begin
            run_start_reg <= run_start_next;
            first_reg     <= first_next;
            peak_reg      <= peak_next;
            peak_time_reg <= peak_time_next;
            j_level_reg   <= j_level_next;
            j_time_reg    <= j_time_next;
            j_seen_reg    <= j_seen_next;
            i_level_reg   <= i_level_next;
            i_time_reg    <= i_time_next;
            i_seen_reg    <= i_seen_next;
        end
    end

endmodule

// ----- src/fte_queue.sv -----
module fte_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  fte_pkg::fte_push_t push,
    output logic               full,
    output logic               pop_valid,
    output fte_pkg::fte_rec_t  pop_rec,
    input  logic               pop_ready
);
    import fte_pkg::*;

    fte_rec_t               slot_reg [Q_DEPTH];
    logic [Q_PTR_BITS-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_BITS-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_BITS-1:0]  count_reg, count_next;
    logic                   do_push;
    logic                   do_pop;

    localparam logic [Q_CNT_BITS-1:0] DEPTH_CNT = Q_CNT_BITS'(Q_DEPTH);
    localparam logic [Q_PTR_BITS-1:0] LAST_PTR  = Q_PTR_BITS'(Q_DEPTH - 1);

    assign full      = (count_reg == DEPTH_CNT);
    assign pop_valid = (count_reg != '0);
    assign pop_rec   = slot_reg[rd_ptr_reg];
    assign do_push   = push.valid && !full;
    assign do_pop    = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push.rec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- src/fte_back.sv -----
module fte_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              pop_valid,
    input  fte_pkg::fte_rec_t pop_rec,
    output logic              pop_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output fte_pkg::fte_out_t m_data
);
    import fte_pkg::*;

    localparam int CNT_BITS = $clog2(RATIO_BITS + 1);
    localparam logic [CNT_BITS-1:0] CNT_START = CNT_BITS'(RATIO_BITS);
    localparam logic [CNT_BITS-1:0] CNT_ONE   = CNT_BITS'(1);

    typedef enum logic [2:0] {
        BK_IDLE = 3'b001,
        BK_DIV  = 3'b010,
        BK_OUT  = 3'b100
    } bk_state_t;

    bk_state_t              state_reg, state_next;
    fte_rec_t               rec_reg, rec_next;
    logic [SAMPLE_BITS-1:0] fv_reg, fv_next;
    logic [SAMPLE_BITS:0]   rem_reg, rem_next;
    logic [RATIO_BITS-1:0]  quo_reg, quo_next;
    logic [CNT_BITS-1:0]    cnt_reg, cnt_next;

    logic [SAMPLE_BITS:0]   shifted;
    logic [SAMPLE_BITS:0]   divisor;
    logic                   q_bit;
    logic                   zero_ratio;

    assign pop_ready = (state_reg == BK_IDLE);
    assign m_valid   = (state_reg == BK_OUT);

    // restoring division, one quotient bit per cycle, no shift on the first step
    assign divisor = {1'b0, rec_reg.fm_level};
    assign shifted = (cnt_reg == CNT_START) ? rem_reg : {rem_reg[SAMPLE_BITS-1:0], 1'b0};
    assign q_bit   = (shifted >= divisor);

    always_comb begin
        state_next = state_reg;
        rec_next   = rec_reg;
        fv_next    = fv_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            BK_IDLE: begin
                if (pop_valid) begin
                    rec_next   = pop_rec;
                    fv_next    = pop_rec.fm_level - pop_rec.fo_level;
                    rem_next   = {1'b0, pop_rec.fm_level - pop_rec.fo_level};
                    quo_next   = '0;
                    cnt_next   = CNT_START;
                    state_next = BK_DIV;
                end
            end
            BK_DIV: begin
                rem_next = q_bit ? shifted - divisor : shifted;
                quo_next = {quo_reg[RATIO_BITS-2:0], q_bit};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CNT_ONE) begin
                    state_next = BK_OUT;
                end
            end
            BK_OUT: begin
                if (m_ready) begin
                    state_next = BK_IDLE;
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    assign zero_ratio = rec_reg.saturated || (rec_reg.fm_level == '0);

    always_comb begin
        m_data.fo_level    = rec_reg.saturated ? '0 : rec_reg.fo_level;
        m_data.fj_level    = rec_reg.fj_level;
        m_data.fj_time_us  = rec_reg.fj_time_us;
        m_data.fi_level    = rec_reg.fi_level;
        m_data.fi_time_us  = rec_reg.fi_time_us;
        m_data.fm_level    = rec_reg.fm_level;
        m_data.fm_time_us  = rec_reg.fm_time_us;
        m_data.fv_level    = rec_reg.saturated ? '0 : fv_reg;
        m_data.yield_ratio = zero_ratio ? '0 : quo_reg;
        m_data.fj_found    = rec_reg.fj_found;
        m_data.fi_found    = rec_reg.fi_found;
        m_data.saturated   = rec_reg.saturated;
    end

    always_ff @(posedge aclk) begin
        rec_reg <= rec_next;
        fv_reg  <= fv_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BK_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// ----- src/fluorescence_transient_extractor.sv -----
// samples: one transaction per cycle while the queue is not full, folded into the run state in the cycle it is taken
// result: m_valid rises after the last sample of a run is accepted, its record is registered in
//   the queue, taken by the idle sequencer and run through the one-bit-per-cycle ratio divider
// results: no new record is taken until the last result is accepted; a two-entry queue holds finished runs meanwhile
// reset: aresetn synchronous, active low; clears run state, queue and sequencer and
//   loads the default window and saturation registers
module fluorescence_transient_extractor (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  fte_pkg::fte_in_t                    s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output fte_pkg::fte_out_t                   m_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [fte_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [fte_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
    import fte_pkg::*;

    fte_cfg_t  cfg_reg, cfg_next;
    fte_push_t push;
    logic      q_full;
    logic      pop_valid;
    logic      pop_ready;
    fte_rec_t  pop_rec;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_J_START:   cfg_next.j_start   = cfg_data[TIME_BITS-1:0];
                CFG_I_START:   cfg_next.i_start   = cfg_data[TIME_BITS-1:0];
                CFG_WIN_LEN:   cfg_next.win_len   = cfg_data[LEN_BITS-1:0];
                CFG_SAT_LEVEL: cfg_next.sat_level = cfg_data[SAMPLE_BITS-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.j_start   <= J_START_RST;
            cfg_reg.i_start   <= I_START_RST;
            cfg_reg.win_len   <= WIN_LEN_RST;
            cfg_reg.sat_level <= SAT_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    fte_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .push    (push)
    );

    fte_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .full      (q_full),
        .pop_valid (pop_valid),
        .pop_rec   (pop_rec),
        .pop_ready (pop_ready)
    );

    fte_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_rec   (pop_rec),
        .pop_ready (pop_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
